// File: hdl/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg
// Types, constants and microcode program of the radix digit string converter.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    localparam logic [5:0] MIN_BASE       = 6'd2;
    localparam logic [5:0] MAX_BASE       = 6'd36;
    localparam logic [5:0] DECIMAL_DIGITS = 6'd10;
    localparam logic [6:0] ASCII_ZERO     = 7'd48;
    localparam logic [6:0] ASCII_LOWER_A  = 7'd97;

    // Sequencer steps, one control word each
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_STORE,
        ST_RD_ADDR,
        ST_EMIT,
        ST_NEXT,
        ST_DONE
    } t_step;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_START,
        COND_BITS_LEFT,
        COND_QUO_NZ,
        COND_OUT_BUSY,
        COND_RD_MORE
    } t_cond;

    // Datapath strobes
    typedef struct packed {
        logic in_rdy;
        logic ld_in;
        logic clr_rem;
        logic div_step;
        logic wr_dig;
        logic rd_en;
        logic emit;
        logic dec_rd;
    } t_ctrl;

    // Datapath status seen by the jump logic
    typedef struct packed {
        logic start_ok;
        logic bits_left;
        logic quo_nz;
        logic out_busy;
        logic rd_more;
    } t_status;

    typedef struct packed {
        t_ctrl ctrl;
        t_cond cond;
        t_step target;
    } t_uword;

    // Microcode program
    function automatic t_uword uword_rom(input t_step step);
        t_uword w;
        w = '0;
        case (step)
            ST_IDLE: begin
                w.ctrl.in_rdy = 1'b1;
                w.ctrl.ld_in  = 1'b1;
                w.cond        = COND_NO_START;
                w.target      = ST_IDLE;
            end
            ST_DIV_INIT: begin
                w.ctrl.clr_rem = 1'b1;
                w.cond         = COND_NONE;
                w.target       = ST_IDLE;
            end
            ST_DIV_STEP: begin
                w.ctrl.div_step = 1'b1;
                w.cond          = COND_BITS_LEFT;
                w.target        = ST_DIV_STEP;
            end
            ST_STORE: begin
                w.ctrl.wr_dig = 1'b1;
                w.cond        = COND_QUO_NZ;
                w.target      = ST_DIV_INIT;
            end
            ST_RD_ADDR: begin
                w.ctrl.rd_en = 1'b1;
                w.cond       = COND_NONE;
                w.target     = ST_IDLE;
            end
            ST_EMIT: begin
                w.ctrl.emit = 1'b1;
                w.cond      = COND_OUT_BUSY;
                w.target    = ST_EMIT;
            end
            ST_NEXT: begin
                w.ctrl.dec_rd = 1'b1;
                w.cond        = COND_RD_MORE;
                w.target      = ST_RD_ADDR;
            end
            ST_DONE: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Map a digit value to lower-case ASCII
    function automatic logic [6:0] digit_ascii(input logic [5:0] d);
        if (d < DECIMAL_DIGITS) begin
            return ASCII_ZERO + {1'b0, d};
        end
        return ASCII_LOWER_A + {1'b0, d - DECIMAL_DIGITS};
    endfunction

endpackage

// File: hdl/radix_digit_string_converter_unit.sv
// The restoring divider runs once per digit and produces one quotient bit per cycle.
// A new value is accepted only in the idle step, after every digit of the last one is emitted.
// An invalid base is taken while idle and gives no word.
// Reset (i_rst_n low, synchronous) clears the step counter, output valid, quotient and digit
// count; the digit store is not cleared.
// ----------------------------------------------------------------------------
// radix_digit_string_converter_unit
// Converts an unsigned value to lower-case ASCII digits in a base from 2 to 36.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_unit #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_number,
    input  logic [5:0]  i_radix,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_digit_char,
    output logic        o_last_digit
);
    import rdsc_pkg::*;

    t_ctrl   w_ctrl;
    t_status w_status;

    // Sequencer
    rdsc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // Datapath
    rdsc_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_status     (w_status),
        .i_in_valid   (i_in_valid),
        .i_number     (i_number),
        .i_radix      (i_radix),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    assign o_in_ready = w_ctrl.in_rdy;

endmodule

// File: hdl/rdsc_ram.sv
// ----------------------------------------------------------------------------
// rdsc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rdsc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rdsc_seq.sv
// ----------------------------------------------------------------------------
// rdsc_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module rdsc_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdsc_pkg::t_status i_status,
    output rdsc_pkg::t_ctrl   o_ctrl
);
    import rdsc_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_take;

    // Hold the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // Fetch the control word and resolve the jump
    always_comb begin
        w_uword = uword_rom(r_step);
        case (w_uword.cond)
            COND_NONE:      w_take = 1'b0;
            COND_ALWAYS:    w_take = 1'b1;
            COND_NO_START:  w_take = !i_status.start_ok;
            COND_BITS_LEFT: w_take = i_status.bits_left;
            COND_QUO_NZ:    w_take = i_status.quo_nz;
            COND_OUT_BUSY:  w_take = i_status.out_busy;
            COND_RD_MORE:   w_take = i_status.rd_more;
            default:        w_take = 1'b1;
        endcase
        n_step = w_take ? w_uword.target : t_step'(r_step + 3'd1);
        o_ctrl = w_uword.ctrl;
    end

    // Last digit stored leads straight to read-out
    a_store_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ST_STORE && !i_status.quo_nz) |=> (r_step == ST_RD_ADDR))
        else $error("store of final digit did not start read-out");

endmodule

// File: hdl/rdsc_dp.sv
// ----------------------------------------------------------------------------
// rdsc_dp
// Datapath: bit-serial divider by the base, digit store, read-out register.
// ----------------------------------------------------------------------------
module rdsc_dp #(
    parameter int VALUE_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdsc_pkg::t_ctrl   i_ctrl,
    output rdsc_pkg::t_status o_status,
    input  logic              i_in_valid,
    input  logic [63:0]       i_number,
    input  logic [5:0]        i_radix,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [6:0]        o_digit_char,
    output logic              o_last_digit
);
    import rdsc_pkg::*;

    localparam int IW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int BW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] r_quo;
    logic [5:0]            r_rem;
    logic [5:0]            r_base;
    logic [BW-1:0]         r_bits;
    logic [CW-1:0]         r_cnt;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_out_valid;
    logic [6:0]            r_char;
    logic                  r_last;
    logic [6:0]            w_trial;
    logic                  w_ge;
    logic [5:0]            w_rdata;
    logic                  w_base_ok;
    logic                  w_out_busy;

    // Check base range and form the next divider trial
    always_comb begin
        w_base_ok  = i_radix inside {[MIN_BASE:MAX_BASE]};
        w_trial    = {r_rem, r_quo[VALUE_BITS-1]};
        w_ge       = w_trial >= {1'b0, r_base};
        w_out_busy = r_out_valid && !i_out_ready;
    end

    // Load, divide one bit per cycle, count stored digits, walk the store back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo <= '0;
            r_cnt <= '0;
        end else begin
            if (i_ctrl.ld_in && i_in_valid && w_base_ok) begin
                r_quo  <= i_number[VALUE_BITS-1:0];
                r_base <= i_radix;
                r_cnt  <= '0;
            end
            if (i_ctrl.clr_rem) begin
                r_rem  <= '0;
                r_bits <= BW'(VALUE_BITS - 1);
            end
            if (i_ctrl.div_step) begin
                r_rem  <= w_ge ? 6'(w_trial - {1'b0, r_base}) : w_trial[5:0];
                r_quo  <= {r_quo[VALUE_BITS-2:0], w_ge};
                r_bits <= r_bits - BW'(1);
            end
            if (i_ctrl.wr_dig) begin
                r_rd_idx <= r_cnt[IW-1:0];
                r_cnt    <= r_cnt + CW'(1);
            end
            if (i_ctrl.dec_rd) begin
                r_rd_idx <= r_rd_idx - IW'(1);
            end
        end
    end

    // Hold the output word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit && !w_out_busy) begin
            r_out_valid <= 1'b1;
            r_char      <= digit_ascii(w_rdata);
            r_last      <= (r_rd_idx == '0);
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    rdsc_ram #(
        .WIDTH (6),
        .DEPTH (VALUE_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_dig),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (r_rem),
        .i_re    (i_ctrl.rd_en),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_status.start_ok  = i_in_valid && w_base_ok;
        o_status.bits_left = (r_bits != '0);
        o_status.quo_nz    = (r_quo != '0);
        o_status.out_busy  = w_out_busy;
        o_status.rd_more   = (r_rd_idx != '0);
    end

    assign o_out_valid  = r_out_valid;
    assign o_digit_char = r_char;
    assign o_last_digit = r_last;

    // Never write past the digit store
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr_dig |-> (r_cnt < CW'(VALUE_BITS)))
        else $error("digit store write beyond depth");

    // An emitted word carries the last flag of store entry zero
    a_emit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit && !w_out_busy) |=> (r_out_valid && r_last == $past(r_rd_idx == '0)))
        else $error("emitted word lost or last flag wrong");

endmodule

// File: dv/radix_digit_string_converter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_string_converter_unit_tb
// Drives values and bases into the converter and checks every digit word.
// A table of directed rows covers zero, full-width values, both ends of the
// base range and rejected bases. A random phase follows. Both sides idle at
// random, and the receiver holds off once for a long stretch. Each returned
// word is compared with a digit string worked out in the bench.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_unit_tb;

    import rdsc_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_digit_word;

    typedef struct {
        logic [63:0] number;
        logic [5:0]  radix;
        bit          typed;
        string       text;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [63:0] i_number;
    logic [5:0]  i_radix;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [6:0]  o_digit_char;
    logic        o_last_digit;

    t_digit_word expected_digits[$];
    t_dir_row    dir_rows[$];
    t_digit_word head_word;

    int  mismatch_count = 0;
    int  words_checked  = 0;
    int  items_sent     = 0;
    int  invalid_sent   = 0;
    int  cycle_count    = 0;
    bit  send_calm      = 1'b0;
    bit  recv_calm      = 1'b0;
    bit  stall_armed    = 1'b0;
    logic out_hold;

    radix_digit_string_converter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_number     (i_number),
        .i_radix      (i_radix),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Draw an idle count, switching now and then into a stretch without gaps
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 11) == 0) begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Work out the digit words of one value in one base
    task automatic predict_digits(input logic [63:0] value, input logic [5:0] base);
        logic [63:0] quo;
        logic [5:0]  rems [64];
        logic [5:0]  d;
        logic [6:0]  ch;
        int          count;
        if (base < MIN_BASE || base > MAX_BASE) begin
            return;
        end
        quo   = value;
        count = 0;
        if (quo == 64'd0) begin
            rems[0] = 6'd0;
            count   = 1;
        end else begin
            while (quo != 64'd0 && count < 64) begin
                rems[count] = 6'(quo % 64'(base));
                quo         = quo / 64'(base);
                count++;
            end
        end
        // Read remainders back, most significant first
        for (int k = count - 1; k >= 0; k--) begin
            d = rems[k];
            if (d < DECIMAL_DIGITS) begin
                ch = ASCII_ZERO + 7'(d);
            end else begin
                ch = ASCII_LOWER_A + 7'(d - DECIMAL_DIGITS);
            end
            expected_digits.push_back('{ch, k == 0});
        end
    endtask

    // Offer one word and hold it until taken, then queue its digits
    task automatic push_word(input logic [63:0] value, input logic [5:0] base,
                             input bit typed, input string text);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_number   <= value;
        i_radix    <= base;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (base < MIN_BASE || base > MAX_BASE) begin
            invalid_sent++;
        end
        if (typed) begin
            for (int i = 0; i < text.len(); i++) begin
                expected_digits.push_back('{7'(text[i]), i == text.len() - 1});
            end
        end else begin
            predict_digits(value, base);
        end
    endtask

    task automatic log_mismatch(input string msg);
        if (mismatch_count < 10) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Check each accepted digit word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_checked++;
            if (expected_digits.size() == 0) begin
                log_mismatch($sformatf("unexpected word: char=%0d last=%0b",
                                       o_digit_char, o_last_digit));
            end else begin
                head_word = expected_digits.pop_front();
                if (o_digit_char !== head_word.ch || o_last_digit !== head_word.last) begin
                    log_mismatch($sformatf("expected char=%0d last=%0b, got char=%0d last=%0b",
                                           head_word.ch, head_word.last,
                                           o_digit_char, o_last_digit));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, expected_digits.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: idle at random, drop ready during the long hold
    initial begin
        int gap;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = draw_gap(recv_calm);
            if (gap > 0 || out_hold) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (out_hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Long receiver hold-off early in the random phase, so the input stalls
    initial begin
        out_hold <= 1'b0;
        wait (stall_armed);
        repeat (40) @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    // Stimulus
    initial begin
        logic [63:0] value;
        logic [5:0]  base;
        int          valid_items;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_number   <= 64'd0;
        i_radix    <= 6'd0;

        // Directed rows: typed text where the answer is obvious
        dir_rows.push_back('{64'd0, 6'd10, 1'b1, "0"});
        dir_rows.push_back('{64'd0, 6'd2, 1'b1, "0"});
        dir_rows.push_back('{64'd0, 6'd36, 1'b1, "0"});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 1'b1,
            "1111111111111111111111111111111111111111111111111111111111111111"});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b1, "ffffffffffffffff"});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 1'b1, "18446744073709551615"});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 1'b0, ""});
        dir_rows.push_back('{64'd35, 6'd36, 1'b1, "z"});
        dir_rows.push_back('{64'd36, 6'd36, 1'b1, "10"});
        dir_rows.push_back('{64'd1, 6'd2, 1'b1, "1"});
        dir_rows.push_back('{64'd2, 6'd2, 1'b1, "10"});
        dir_rows.push_back('{64'd9, 6'd10, 1'b1, "9"});
        dir_rows.push_back('{64'd10, 6'd11, 1'b1, "a"});
        dir_rows.push_back('{64'd255, 6'd16, 1'b1, "ff"});
        // Rejected bases give no word; the untyped rows are worked out by the bench
        dir_rows.push_back('{64'd5, 6'd0, 1'b1, ""});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd1, 1'b1, ""});
        dir_rows.push_back('{64'd100, 6'd37, 1'b1, ""});
        dir_rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1, ""});
        dir_rows.push_back('{64'h8000_0000_0000_0000, 6'd2, 1'b0, ""});
        dir_rows.push_back('{64'hAAAA_AAAA_AAAA_AAAA, 6'd8, 1'b0, ""});
        dir_rows.push_back('{64'h5555_5555_5555_5555, 6'd36, 1'b0, ""});
        dir_rows.push_back('{64'd12345, 6'd7, 1'b0, ""});
        dir_rows.push_back('{64'd0, 6'd63, 1'b1, ""});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            push_word(dir_rows[i].number, dir_rows[i].radix, dir_rows[i].typed,
                      dir_rows[i].text);
        end

        // Random phase: mostly valid bases, mixed value widths, a few slow ones
        stall_armed = 1'b1;
        valid_items = 0;
        while (valid_items < RANDOM_ITEMS) begin
            value = {$urandom, $urandom};
            if ($urandom_range(0, 15) == 0) begin
                base = MIN_BASE;
                value[63] = 1'b1;
            end else begin
                value = value >> $urandom_range(0, 64);
                base  = 6'($urandom_range(MIN_BASE, MAX_BASE));
            end
            if ($urandom_range(0, 7) == 0) begin
                base = $urandom_range(0, 1) ? 6'($urandom_range(0, 1))
                                            : 6'($urandom_range(37, 63));
            end else begin
                valid_items++;
            end
            push_word(value, base, 1'b0, "");
        end
        i_in_valid <= 1'b0;

        // Drain
        while (expected_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d directed rows and %0d items in all, %0d with a rejected base",
                 dir_rows.size(), items_sent, invalid_sent);
        $display("Checked %0d digit words over %0d cycles, %0d mismatches",
                 words_checked, cycle_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/rdsc_pkg.sv
hdl/rdsc_ram.sv
hdl/rdsc_seq.sv
hdl/rdsc_dp.sv
hdl/radix_digit_string_converter_unit.sv
dv/radix_digit_string_converter_unit_tb.sv
